// File: rtl/bdrc_pkg.sv
package bdrc_pkg;

  // Reset value of the min_match register
  localparam logic [15:0] MIN_MATCH_RESET = 16'd20;

  // Record queue between classifier and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_PAIR = 2'd0,
    OP_DEL  = 2'd1,
    OP_INS  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Classifier phase
  typedef enum logic [1:0] {
    PH_SUB = 2'd0,
    PH_MAT = 2'd1,
    PH_DEL = 2'd2,
    PH_INS = 2'd3
  } phase_e;

  // Run kinds as reported
  typedef enum logic [1:0] {
    KIND_MAT = 2'd0,
    KIND_SUB = 2'd1,
    KIND_DEL = 2'd2,
    KIND_INS = 2'd3
  } kind_e;

  // One run record
  typedef struct packed {
    kind_e       kind;
    logic [31:0] len;
    logic        last;
  } rec_t;

  // Records produced by one request, in order (rec0 first)
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  // Record kind for the run open in a given phase
  function automatic kind_e phase_kind(phase_e ph);
    kind_e k;
    unique case (ph)
      PH_SUB:  k = KIND_SUB;
      PH_MAT:  k = KIND_MAT;
      PH_DEL:  k = KIND_DEL;
      PH_INS:  k = KIND_INS;
      default: k = KIND_SUB;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/bdrc_front.sv
module bdrc_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     op_i,
  input  logic [7:0]     byte_a_i,
  input  logic [7:0]     byte_b_i,
  input  logic           final_i,
  input  logic           cfg_valid_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           room_i,
  output bdrc_pkg::push_t push_o
);
  import bdrc_pkg::*;

  localparam int SW  = (LENGTH_BITS > 17) ? LENGTH_BITS : 17;
  localparam int LBX = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam logic [SW:0] LenMaxW =
    {{(SW + 1 - LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

  function automatic logic [LENGTH_BITS-1:0] sat_add(logic [LENGTH_BITS-1:0] a,
                                                     logic [16:0] b);
    logic [SW:0] bw;
    logic [SW:0] sum;
    bw = (SW + 1)'(b);
    if (bw > LenMaxW) bw = LenMaxW;
    sum = (SW + 1)'(a) + bw;
    if (sum > LenMaxW) sum = LenMaxW;
    return sum[LENGTH_BITS-1:0];
  endfunction

  function automatic logic [31:0] to_len(logic [LENGTH_BITS-1:0] x);
    logic [LBX-1:0] w;
    w = LBX'(x);
    return w[31:0];
  endfunction

  logic [15:0]            min_match_q;
  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [15:0]            mss_q, mss_d;

  logic                   accept;
  logic [15:0]            mm;
  logic [16:0]            mss_inc;
  phase_e                 ph1;
  logic [LENGTH_BITS-1:0] cnt1;
  logic [15:0]            mss1;
  logic                   e0, e1;
  rec_t                   r0, r1;
  logic [LENGTH_BITS-1:0] close0_len, close1_len;

  assign in_ready_o = room_i;
  assign accept     = in_valid_i & room_i;
  assign mm         = (min_match_q == 16'd0) ? 16'd1 : min_match_q;
  assign mss_inc    = {1'b0, mss_q} + 17'd1;

  // Length of the open run if it were closed now, before and after the step
  assign close0_len = (phase_q == PH_SUB) ? sat_add(cnt_q, {1'b0, mss_q}) : cnt_q;
  assign close1_len = (ph1 == PH_SUB) ? sat_add(cnt1, {1'b0, mss1}) : cnt1;

  // Apply the item to the run state
  always_comb begin
    ph1  = phase_q;
    cnt1 = cnt_q;
    mss1 = mss_q;
    e0   = 1'b0;
    r0   = '{kind: phase_kind(phase_q), len: to_len(close0_len), last: 1'b0};
    unique case (op_e'(op_i))
      OP_PAIR: begin
        if (phase_q == PH_SUB) begin
          if (byte_a_i != byte_b_i) begin
            cnt1 = sat_add(cnt_q, mss_inc);
            mss1 = 16'd0;
          end else if (mss_inc >= {1'b0, mm}) begin
            e0   = (cnt_q != '0);
            r0   = '{kind: KIND_SUB, len: to_len(cnt_q), last: 1'b0};
            ph1  = PH_MAT;
            cnt1 = sat_add('0, mss_inc);
            mss1 = 16'd0;
          end else begin
            mss1 = mss_inc[15:0];
          end
        end else if (phase_q == PH_MAT) begin
          if (byte_a_i == byte_b_i) begin
            cnt1 = sat_add(cnt_q, 17'd1);
          end else begin
            e0   = 1'b1;
            r0   = '{kind: KIND_MAT, len: to_len(cnt_q), last: 1'b0};
            ph1  = PH_SUB;
            cnt1 = LENGTH_BITS'(1);
            mss1 = 16'd0;
          end
        end
      end
      OP_DEL, OP_INS: begin
        if (phase_q == ((op_e'(op_i) == OP_DEL) ? PH_DEL : PH_INS)) begin
          cnt1 = sat_add(cnt_q, 17'd1);
        end else begin
          e0   = (close0_len != '0);
          ph1  = (op_e'(op_i) == OP_DEL) ? PH_DEL : PH_INS;
          cnt1 = LENGTH_BITS'(1);
          mss1 = 16'd0;
        end
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  // Close out the comparison on the final item
  always_comb begin
    e1 = final_i & (close1_len != '0);
    r1 = '{kind: phase_kind(ph1), len: to_len(close1_len), last: 1'b1};
    phase_d = ph1;
    cnt_d   = cnt1;
    mss_d   = mss1;
    if (final_i) begin
      phase_d = PH_SUB;
      cnt_d   = '0;
      mss_d   = 16'd0;
    end
  end

  // Pack records for the queue in report order
  always_comb begin
    push_o.cnt  = 2'd0;
    push_o.rec0 = r0;
    push_o.rec1 = r1;
    if (accept) begin
      push_o.cnt = {1'b0, e0} + {1'b0, e1};
      if (!e0) push_o.rec0 = r1;
      else if (final_i && !e1) push_o.rec0.last = 1'b1;
    end
  end

  // Hold state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_match_q <= MIN_MATCH_RESET;
      phase_q     <= PH_SUB;
      cnt_q       <= '0;
      mss_q       <= 16'd0;
    end else begin
      if (cfg_valid_i) min_match_q <= cfg_data_i;
      if (accept) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        mss_q   <= mss_d;
      end
    end
  end

endmodule

// File: rtl/bdrc_queue.sv
module bdrc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdrc_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  output bdrc_pkg::rec_t  rec_o,
  input  logic            pop_i
);
  import bdrc_pkg::*;

  rec_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           pop;

  // Leave room for the two records one request can make
  assign room_o  = (cnt_q <= (QAW + 1)'(QDEPTH - 2));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign pop     = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q + QAW'(push_i.cnt);
    rd_d  = rd_q + QAW'(pop);
    cnt_d = cnt_q + (QAW + 1)'(push_i.cnt) - (QAW + 1)'(pop);
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store records
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.rec0;
    if (push_i.cnt == 2'd2) mem_q[wr_q + QAW'(1)] <= push_i.rec1;
  end

endmodule

// File: rtl/bdrc_back.sv
module bdrc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  bdrc_pkg::rec_t rec_i,
  output logic           pop_o,
  output logic           valid_o,
  output bdrc_pkg::rec_t rec_o,
  input  logic           ready_i
);
  import bdrc_pkg::*;

  logic valid_q;
  rec_t rec_q;

  assign pop_o   = valid_i & (~valid_q | ready_i);
  assign valid_o = valid_q;
  assign rec_o   = rec_q;

  // Refill the output register when it empties or is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || ready_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= rec_i;
  end

endmodule

// File: rtl/byte_diff_run_classifier.sv
// Byte stream compare, reported as runs of match / substitution / deletion / insertion.
// Input stream: one request per byte position. tuser is the op (pair, first-only,
// second-only), tdata carries both bytes, tlast marks the last request of a comparison.
// Output stream: one run record per beat, tdata is the run length (saturating),
// tuser the run kind, tlast set on the final record of a comparison.
// cfg channel writes min_match; always ready, write only while idle.
// Throughput: one request per cycle while the queue has room. A request makes zero, one or two
// records; the output side moves one record per cycle while the sink is ready, so sustained
// rate follows record count. A record passes through the queue write, then the output
// register, before it appears on the output.
// A four-entry record queue sits between classifier and output register; input
// ready drops while fewer than two queue slots are free, so an output stall
// backs up into the input without losing records.
// Reset clears run state, empties the queue and sets min_match to 20.
module byte_diff_run_classifier #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_a [7:0], byte_b [15:8]
  input  logic [1:0]  s_axis_tuser,   // op [1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // run_length [31:0]
  output logic [1:0]  m_axis_tuser,   // run_kind [1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import bdrc_pkg::*;

  push_t push;
  logic  room;
  logic  q_valid;
  rec_t  q_rec;
  logic  pop;
  rec_t  out_rec;

  assign cfg_ready_o = 1'b1;

  bdrc_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .byte_a_i   (s_axis_tdata[7:0]),
    .byte_b_i   (s_axis_tdata[15:8]),
    .final_i    (s_axis_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .room_i     (room),
    .push_o     (push)
  );

  bdrc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(q_valid),
    .rec_o  (q_rec),
    .pop_i  (pop)
  );

  bdrc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .rec_i  (q_rec),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid),
    .rec_o  (out_rec),
    .ready_i(m_axis_tready)
  );

  assign m_axis_tdata = out_rec.len;
  assign m_axis_tuser = out_rec.kind;
  assign m_axis_tlast = out_rec.last;

endmodule

// File: verif/testbench.sv
module testbench;
  import bdrc_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [63:0] LEN_CEIL    = 64'hFFFF_FFFF;

  // One input request as the generator sees it
  typedef struct {
    op_e        op;
    logic [7:0] a;
    logic [7:0] b;
    bit         fin;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  // Run classifier mirror
  logic [15:0] min_match_q = MIN_MATCH_RESET;
  phase_e      ph_q = PH_SUB;
  logic [63:0] run_len_q = '0;
  logic [31:0] matches_q = '0;

  rec_t exp_runs[$];
  rec_t item_runs[$];
  req_t script[$];

  int  err_count = 0;
  int  cycles = 0;
  int  sent = 0;
  int  sink_stall = 0;
  bit  calm = 1'b0;

  byte_diff_run_classifier u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // Stall the record sink
  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      sink_stall <= pick_gap();
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycles, what);
    err_count++;
  endtask

  function automatic logic [63:0] sat_sum(input logic [63:0] x, input logic [63:0] y);
    if (x > LEN_CEIL) x = LEN_CEIL;
    if (y > LEN_CEIL) y = LEN_CEIL;
    if (x > LEN_CEIL - y) return LEN_CEIL;
    return x + y;
  endfunction

  function automatic void emit_run(input kind_e k, input logic [63:0] len, input logic lst);
    rec_t r;
    r.kind = k;
    r.len  = len[31:0];
    r.last = lst;
    item_runs.push_back(r);
  endfunction

  // Report the open run unless it is empty
  function automatic void close_open_run(input logic lst);
    logic [63:0] len;
    case (ph_q)
      PH_SUB: begin
        len = sat_sum(run_len_q, {32'd0, matches_q});
        if (len > 0) emit_run(KIND_SUB, len, lst);
      end
      PH_MAT: if (run_len_q > 0) emit_run(KIND_MAT, run_len_q, lst);
      PH_DEL: if (run_len_q > 0) emit_run(KIND_DEL, run_len_q, lst);
      default: if (run_len_q > 0) emit_run(KIND_INS, run_len_q, lst);
    endcase
  endfunction

  function automatic void pair_step(input logic [7:0] a, input logic [7:0] b);
    logic [31:0] need;
    need = (min_match_q == 16'd0) ? 32'd1 : {16'd0, min_match_q};
    if (ph_q == PH_SUB) begin
      if (a != b) begin
        run_len_q = sat_sum(run_len_q, {32'd0, matches_q} + 64'd1);
        matches_q = '0;
      end else begin
        matches_q++;
        if (matches_q >= need) begin
          if (run_len_q > 0) emit_run(KIND_SUB, run_len_q, 1'b0);
          ph_q = PH_MAT;
          run_len_q = sat_sum(64'd0, {32'd0, matches_q});
          matches_q = '0;
        end
      end
    end else if (ph_q == PH_MAT) begin
      if (a == b) begin
        run_len_q = sat_sum(run_len_q, 64'd1);
      end else begin
        emit_run(KIND_MAT, run_len_q, 1'b0);
        ph_q = PH_SUB;
        run_len_q = 64'd1;
        matches_q = '0;
      end
    end
    // leftover phases drop pairs
  endfunction

  function automatic void leftover_step(input phase_e target);
    if (ph_q == target) begin
      run_len_q = sat_sum(run_len_q, 64'd1);
    end else begin
      close_open_run(1'b0);
      ph_q = target;
      run_len_q = 64'd1;
      matches_q = '0;
    end
  endfunction

  // Advance the mirror by one accepted request and queue its records
  function automatic void predict_runs(input req_t it);
    item_runs.delete();
    case (it.op)
      OP_PAIR: pair_step(it.a, it.b);
      OP_DEL:  leftover_step(PH_DEL);
      OP_INS:  leftover_step(PH_INS);
      default: ;
    endcase
    if (it.fin) begin
      close_open_run(1'b1);
      if (item_runs.size() > 0) item_runs[item_runs.size() - 1].last = 1'b1;
      ph_q = PH_SUB;
      run_len_q = '0;
      matches_q = '0;
    end
    foreach (item_runs[i]) exp_runs.push_back(item_runs[i]);
  endfunction

  // Check each record taken from the block
  always @(posedge clk_i) begin
    rec_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected record kind %0d len %0d last %0b",
                                  m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        r = exp_runs.pop_front();
        if (m_axis_tuser != r.kind)
          report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, r.kind));
        if (m_axis_tdata != r.len)
          report_mismatch($sformatf("length %0d, want %0d", m_axis_tdata, r.len));
        if (m_axis_tlast != r.last)
          report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, r.last));
      end
    end
  end

  // Send one request; returns at the falling edge after it was taken
  task automatic send_req(input req_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {it.b, it.a};
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.fin;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_runs(it);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send(input op_e op, input logic [7:0] a, input logic [7:0] b,
                      input bit fin);
    req_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    it.fin = fin;
    send_req(it);
  endtask

  // Hold input idle until every record is out, plus pipeline slack
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (exp_runs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_min_match(input logic [15:0] value);
    drain();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    min_match_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset threshold: leftovers, ignored pairs, empty closes, byte extremes
  task automatic test_edge_cases();
    send(OP_NONE, 8'h00, 8'h00, 1'b1);
    send(OP_PAIR, 8'h00, 8'h00, 1'b1);
    send(OP_PAIR, 8'hFF, 8'h00, 1'b0);
    send(OP_PAIR, 8'h00, 8'hFF, 1'b0);
    send(OP_NONE, 8'hFF, 8'hFF, 1'b0);
    send(OP_PAIR, 8'hFF, 8'hFF, 1'b1);
    send(OP_DEL,  8'h00, 8'h00, 1'b0);
    send(OP_DEL,  8'hFF, 8'h00, 1'b0);
    send(OP_PAIR, 8'h12, 8'h34, 1'b0);
    send(OP_INS,  8'h00, 8'hFF, 1'b0);
    send(OP_DEL,  8'h00, 8'h00, 1'b0);
    send(OP_NONE, 8'h00, 8'h00, 1'b1);
    send(OP_INS,  8'h00, 8'h00, 1'b1);
    send(OP_PAIR, 8'h5A, 8'hA5, 1'b0);
    send(OP_DEL,  8'h00, 8'h00, 1'b1);
  endtask

  // Threshold of one and of zero (zero acts as one)
  task automatic test_tiny_min_match();
    write_min_match(16'd1);
    send(OP_PAIR, 8'h3C, 8'h3C, 1'b0);
    send(OP_PAIR, 8'hC3, 8'hC3, 1'b0);
    send(OP_PAIR, 8'h01, 8'h80, 1'b0);
    send(OP_PAIR, 8'h7F, 8'hFE, 1'b0);
    send(OP_PAIR, 8'h80, 8'h80, 1'b0);
    send(OP_PAIR, 8'h00, 8'h01, 1'b1);
    write_min_match(16'd0);
    send(OP_PAIR, 8'h11, 8'h11, 1'b0);
    send(OP_PAIR, 8'h22, 8'h23, 1'b1);
  endtask

  function automatic void add_pair(input bit same);
    req_t it;
    it.op = OP_PAIR;
    it.a = 8'($urandom_range(0, 255));
    it.b = same ? it.a : (it.a ^ 8'($urandom_range(1, 255)));
    it.fin = 1'b0;
    script.push_back(it);
  endfunction

  function automatic void add_other(input op_e op, input int count);
    req_t it;
    it.op = op;
    it.fin = 1'b0;
    repeat (count) begin
      it.a = 8'($urandom_range(0, 255));
      it.b = 8'($urandom_range(0, 255));
      script.push_back(it);
    end
  endfunction

  // One comparison: alternating stretches near the threshold, optional leftovers
  function automatic void build_compare(input int need);
    int  segs;
    int  len;
    bit  miss;
    op_e left;
    script.delete();
    segs = $urandom_range(0, 4);
    miss = 1'($urandom_range(0, 1));
    for (int s = 0; s < segs; s++) begin
      if (miss) begin
        len = $urandom_range(1, 4);
      end else begin
        case ($urandom_range(0, 5))
          0: len = need - 1;
          1: len = need;
          2: len = need + 1;
          default: len = $urandom_range(1, 2 * need);
        endcase
        if (len < 1) len = 1;
        if (len > 45) len = $urandom_range(1, 45);
      end
      repeat (len) add_pair(!miss);
      if ($urandom_range(0, 14) == 0) add_other(OP_NONE, 1);
      miss = !miss;
    end
    if (segs == 0 || $urandom_range(0, 2) == 0) begin
      left = $urandom_range(0, 1) ? OP_DEL : OP_INS;
      add_other(left, $urandom_range(1, 5));
      if ($urandom_range(0, 4) == 0)
        add_other(left == OP_DEL ? OP_INS : OP_DEL, $urandom_range(1, 3));
      if ($urandom_range(0, 5) == 0) add_pair(1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 7) == 0) add_other(OP_NONE, 1);
    script[script.size() - 1].fin = 1'b1;
  endfunction

  // Random comparisons at one threshold
  task automatic test_random_compares(input logic [15:0] threshold, input int count,
                                      input bit quiet);
    int stop_at;
    write_min_match(threshold);
    calm = quiet;
    stop_at = sent + count;
    while (sent < stop_at) begin
      build_compare(threshold == 16'd0 ? 1 : int'(threshold));
      foreach (script[i]) send_req(script[i]);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_edge_cases();
    test_tiny_min_match();
    test_random_compares(16'd20, 90, 1'b0);
    test_random_compares(16'd1, 80, 1'b0);
    test_random_compares(16'd0, 60, 1'b1);
    test_random_compares(16'd3, 80, 1'b0);
    test_random_compares(16'd65535, 50, 1'b0);
    test_random_compares(16'd7, 80, 1'b0);
    test_random_compares(16'd2, 60, 1'b0);
    drain();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bdrc_pkg.sv
rtl/bdrc_front.sv
rtl/bdrc_queue.sv
rtl/bdrc_back.sv
rtl/byte_diff_run_classifier.sv
verif/testbench.sv
